>>> rtl/amp_pkg.sv
`default_nettype none

package amp_pkg;

	localparam int MAX_TRACKS     = 16;
	localparam int GAIN_FRAC_BITS = 14;
	localparam int QUEUE_DEPTH    = 4;

	localparam int SMP_W   = 16;
	localparam int GAIN_W  = 15;
	localparam int PEAK_W  = 15;
	localparam int SRC_W   = 5;
	localparam int TRK_W   = 4;
	localparam int ACC_W   = 40;
	localparam int PROD_W  = SMP_W + GAIN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [SRC_W-1:0]  SRC_MASTER = SRC_W'(MAX_TRACKS);
	localparam logic [SRC_W-1:0]  SRC_MIC    = SRC_W'(MAX_TRACKS + 1);
	localparam logic [PEAK_W-1:0] PEAK_MAX   = {PEAK_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASTER_GAIN_LEFT  = 3'd0,
		REG_MASTER_GAIN_RIGHT = 3'd1,
		REG_RECORD_SOURCE     = 3'd2,
		REG_THRESHOLD_LEVEL   = 3'd3,
		REG_LISTEN_ENABLE     = 3'd4,
		REG_ARM_ENABLE        = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] master_gain_left;
		logic [GAIN_W-1:0] master_gain_right;
		logic [SRC_W-1:0]  record_source;
		logic [PEAK_W-1:0] threshold_level;
		logic              listen_enable;
		logic              arm_enable;
	} cfg_t;

	typedef struct packed {
		logic                     channel;
		logic signed [PROD_W-1:0] prod;
		logic                     enabled;
		logic [PEAK_W-1:0]        trk_peak;
		logic                     last_track;
		logic                     last_of_buffer;
	} entry_t;

endpackage

`default_nettype wire

>>> rtl/amp_item_if.sv
`default_nettype none

interface amp_item_if;
	logic               valid;
	logic               ready;
	logic               channel;
	logic signed [15:0] track_sample;
	logic [14:0]        track_gain;
	logic [3:0]         track_number;
	logic               track_enabled;
	logic               last_track;
	logic               last_of_buffer;

	modport source (
		output valid, channel, track_sample, track_gain, track_number,
		track_enabled, last_track, last_of_buffer,
		input ready
	);
	modport sink (
		input valid, channel, track_sample, track_gain, track_number,
		track_enabled, last_track, last_of_buffer,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/amp_result_if.sv
`default_nettype none

interface amp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic               out_channel;
	logic [14:0]        peak_level;
	logic               peak_report;
	logic               start_recording;

	modport source (
		output valid, mixed_sample, out_channel, peak_level, peak_report,
		start_recording,
		input ready
	);
	modport sink (
		input valid, mixed_sample, out_channel, peak_level, peak_report,
		start_recording,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/amp_cfg_if.sv
`default_nettype none

interface amp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [14:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/audio_mixer_peak_trigger.sv
// Channel  Dir  Handshake      Carries
// item     in   valid / ready  one track's sample for one channel
// result   out  valid / ready  mixed sample and buffer peak report
// cfg      in   valid / ready  register index and write data
//
// Sustained rate is one word per cycle while results are taken; the accumulator add
// in the first back stage is the loop that sets it. A result, which only a last-track
// or reporting end-of-buffer word yields, passes input register, queue, accumulate,
// master multiply and output. Reset clears the accumulator, the peak, the trigger flag
// and all valid bits. A stalled result holds the back pipeline; the queue keeps the
// front moving until its entries fill.
`default_nettype none

module audio_mixer_peak_trigger #(
	parameter int GAIN_FRAC   = amp_pkg::GAIN_FRAC_BITS,
	parameter int QUEUE_DEPTH = amp_pkg::QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	amp_item_if.sink     item,
	amp_result_if.source result,
	amp_cfg_if.sink      cfg
);
	import amp_pkg::*;

	cfg_t   cfg_q;
	logic   clr_spent;
	logic   push;
	entry_t push_data;
	logic   full;
	logic   pop;
	entry_t head;
	logic   empty;

	assign cfg.ready = 1'b1;
	assign clr_spent = cfg.valid && (cfg.index == REG_ARM_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_gain_left  <= 15'd16384;
			cfg_q.master_gain_right <= 15'd16384;
			cfg_q.record_source     <= SRC_MASTER;
			cfg_q.threshold_level   <= '0;
			cfg_q.listen_enable     <= 1'b0;
			cfg_q.arm_enable        <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MASTER_GAIN_LEFT:  cfg_q.master_gain_left  <= cfg.data[GAIN_W-1:0];
				REG_MASTER_GAIN_RIGHT: cfg_q.master_gain_right <= cfg.data[GAIN_W-1:0];
				REG_RECORD_SOURCE:     cfg_q.record_source     <= cfg.data[SRC_W-1:0];
				REG_THRESHOLD_LEVEL:   cfg_q.threshold_level   <= cfg.data[PEAK_W-1:0];
				REG_LISTEN_ENABLE:     cfg_q.listen_enable     <= cfg.data[0];
				REG_ARM_ENABLE:        cfg_q.arm_enable        <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	amp_front #(
		.GAIN_FRAC (GAIN_FRAC)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_regs  (cfg_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	amp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	amp_back #(
		.GAIN_FRAC (GAIN_FRAC)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.cfg_regs  (cfg_q),
		.clr_spent (clr_spent),
		.result    (result)
	);

endmodule

`default_nettype wire

>>> rtl/amp_fifo.sv
`default_nettype none

module amp_fifo #(
	parameter int DEPTH = amp_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire amp_pkg::entry_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output amp_pkg::entry_t      pop_data,
	output logic                 empty
);
	import amp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/amp_front.sv
`default_nettype none

module amp_front #(
	parameter int GAIN_FRAC = amp_pkg::GAIN_FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	amp_item_if.sink           item,
	input  wire amp_pkg::cfg_t cfg_regs,
	output logic               push,
	output amp_pkg::entry_t    push_data,
	input  wire logic          full
);
	import amp_pkg::*;

	logic                    valid_s1;
	logic                    channel_s1;
	logic signed [SMP_W-1:0] sample_s1;
	logic [GAIN_W-1:0]       gain_s1;
	logic [TRK_W-1:0]        track_s1;
	logic                    enabled_s1;
	logic                    last_track_s1;
	logic                    last_buf_s1;

	logic signed [31:0] prod;
	logic signed [31:0] level;
	logic               hit;
	logic               accept;

	assign item.ready = !valid_s1 || !full;
	assign accept     = item.valid && item.ready;
	assign push       = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			channel_s1    <= item.channel;
			sample_s1     <= item.track_sample;
			gain_s1       <= item.track_gain;
			track_s1      <= item.track_number;
			enabled_s1    <= item.track_enabled;
			last_track_s1 <= item.last_track;
			last_buf_s1   <= item.last_of_buffer;
		end
	end

	always_comb begin
		prod  = sample_s1 * $signed({1'b0, gain_s1});
		level = prod >>> GAIN_FRAC;
		hit   = enabled_s1 && (cfg_regs.record_source == {1'b0, track_s1});

		push_data.channel        = channel_s1;
		push_data.prod           = prod[PROD_W-1:0];
		push_data.enabled        = enabled_s1;
		push_data.last_track     = last_track_s1;
		push_data.last_of_buffer = last_buf_s1;
		if (!hit || level <= 0) begin
			push_data.trk_peak = '0;
		end else if (level > 32'(PEAK_MAX)) begin
			push_data.trk_peak = PEAK_MAX;
		end else begin
			push_data.trk_peak = level[PEAK_W-1:0];
		end
	end

endmodule

`default_nettype wire

>>> rtl/amp_back.sv
`default_nettype none

module amp_back #(
	parameter int GAIN_FRAC = amp_pkg::GAIN_FRAC_BITS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire amp_pkg::entry_t head,
	input  wire logic            empty,
	output logic                 pop,
	input  wire amp_pkg::cfg_t   cfg_regs,
	input  wire logic            clr_spent,
	amp_result_if.source         result
);
	import amp_pkg::*;

	localparam int MIX_W = GAIN_FRAC + 17;
	localparam int TOT_W = MIX_W + 16;
	localparam logic signed [ACC_W-1:0] CLAMP_HI = ACC_W'(1) << (MIX_W - 2);
	localparam logic signed [ACC_W-1:0] CLAMP_LO = -CLAMP_HI;
	localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [TOT_W-1:0] SMP_MAX  = TOT_W'(32767);
	localparam logic signed [TOT_W-1:0] SMP_MIN  = TOT_W'(-32768);

	logic signed [ACC_W-1:0] acc_q;
	logic [PEAK_W-1:0]       peak_q;
	logic                    spent_q;

	logic                    valid_s1;
	logic                    channel_s1;
	logic                    last_track_s1;
	logic                    last_buf_s1;
	logic [PEAK_W-1:0]       trk_peak_s1;
	logic signed [MIX_W-1:0] mix_s1;

	logic                    valid_s2;
	logic                    channel_s2;
	logic                    last_track_s2;
	logic                    last_buf_s2;
	logic [PEAK_W-1:0]       trk_peak_s2;
	logic signed [TOT_W-1:0] prod_s2;

	logic                    res_valid_q;
	logic signed [SMP_W-1:0] mixed_q;
	logic                    out_channel_q;
	logic [PEAK_W-1:0]       peak_level_q;
	logic                    peak_report_q;
	logic                    start_q;

	logic                    adv;
	logic signed [PROD_W-1:0] level;
	logic signed [ACC_W:0]   sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic signed [ACC_W-1:0] acc_new;
	logic signed [ACC_W-1:0] acc_clamped;
	logic [GAIN_W-1:0]       master_gain;
	logic signed [TOT_W-1:0] total;
	logic signed [SMP_W-1:0] mix_clip;
	logic [PEAK_W-1:0]       mst_peak;
	logic [PEAK_W-1:0]       peak_a;
	logic [PEAK_W-1:0]       peak_b;
	logic                    report;
	logic                    start;
	logic                    emit;

	assign adv = !res_valid_q || result.ready;
	assign pop = adv && !empty;

	always_comb begin
		level = head.prod >>> GAIN_FRAC;
		sum   = (ACC_W+1)'(acc_q) + (ACC_W+1)'(level);
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = sum[ACC_W-1:0];
		end
		acc_new = head.enabled ? acc_sat : acc_q;
		if (acc_new > CLAMP_HI) begin
			acc_clamped = CLAMP_HI;
		end else if (acc_new < CLAMP_LO) begin
			acc_clamped = CLAMP_LO;
		end else begin
			acc_clamped = acc_new;
		end
		master_gain = channel_s1 ? cfg_regs.master_gain_right : cfg_regs.master_gain_left;
	end

	always_comb begin
		total = prod_s2 >>> GAIN_FRAC;
		if (total > SMP_MAX) begin
			mix_clip = SMP_MAX[SMP_W-1:0];
		end else if (total < SMP_MIN) begin
			mix_clip = SMP_MIN[SMP_W-1:0];
		end else begin
			mix_clip = total[SMP_W-1:0];
		end
		if (last_track_s2 && cfg_regs.record_source == SRC_MASTER && mix_clip > 0) begin
			mst_peak = mix_clip[PEAK_W-1:0];
		end else begin
			mst_peak = '0;
		end
		peak_a = (trk_peak_s2 > peak_q) ? trk_peak_s2 : peak_q;
		peak_b = (mst_peak > peak_a) ? mst_peak : peak_a;
		report = last_buf_s2 && cfg_regs.listen_enable && cfg_regs.record_source != SRC_MIC;
		start  = report && cfg_regs.arm_enable && !spent_q
			&& (peak_b > cfg_regs.threshold_level);
		emit   = last_track_s2 || report;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			peak_q      <= '0;
			spent_q     <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= head.last_track ? '0 : acc_new;
			end
			if (adv) begin
				valid_s1    <= !empty;
				valid_s2    <= valid_s1;
				res_valid_q <= valid_s2 && emit;
				if (valid_s2) begin
					peak_q <= last_buf_s2 ? '0 : peak_b;
				end
			end
			if (clr_spent) begin
				spent_q <= 1'b0;
			end else if (adv && valid_s2 && start) begin
				spent_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			channel_s1    <= head.channel;
			last_track_s1 <= head.last_track;
			last_buf_s1   <= head.last_of_buffer;
			trk_peak_s1   <= head.enabled ? head.trk_peak : '0;
			mix_s1        <= acc_clamped[MIX_W-1:0];
		end
		if (adv) begin
			channel_s2    <= channel_s1;
			last_track_s2 <= last_track_s1;
			last_buf_s2   <= last_buf_s1;
			trk_peak_s2   <= trk_peak_s1;
			prod_s2       <= mix_s1 * $signed({1'b0, master_gain});
			mixed_q       <= last_track_s2 ? mix_clip : '0;
			out_channel_q <= last_track_s2 ? channel_s2 : 1'b0;
			peak_level_q  <= report ? peak_b : '0;
			peak_report_q <= report;
			start_q       <= start;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.mixed_sample    = mixed_q;
	assign result.out_channel     = out_channel_q;
	assign result.peak_level      = peak_level_q;
	assign result.peak_report     = peak_report_q;
	assign result.start_recording = start_q;

endmodule

`default_nettype wire

>>> rtl/amp_chk.sv
`default_nettype none

module amp_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [15:0] mixed_sample,
	input wire logic        out_channel,
	input wire logic [14:0] peak_level,
	input wire logic        peak_report,
	input wire logic        start_recording,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	// A word that waits must keep its contents until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(mixed_sample)
			&& $stable(out_channel) && $stable(peak_level)
			&& $stable(peak_report) && $stable(start_recording))
		else $error("result word changed while stalled");

	// The record trigger only fires together with a peak report.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && start_recording |-> peak_report)
		else $error("start_recording without peak_report");

	// Without a report the peak fields are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !peak_report |-> peak_level == 15'd0 && !start_recording)
		else $error("peak fields set without a report");

	// The result channel is quiet while reset is held.
	assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid during reset");

	// Register writes are never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind audio_mixer_peak_trigger amp_chk u_amp_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.mixed_sample    (result.mixed_sample),
	.out_channel     (result.out_channel),
	.peak_level      (result.peak_level),
	.peak_report     (result.peak_report),
	.start_recording (result.start_recording),
	.cfg_valid       (cfg.valid),
	.cfg_ready       (cfg.ready)
);

`default_nettype wire
